@@ sv/presence_sentence_parser_defines.svh @@
// Assertion macros shared by the parser blocks.
`ifndef PRESENCE_SENTENCE_PARSER_DEFINES_SVH
`define PRESENCE_SENTENCE_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF

// Expression must hold at every edge outside reset
`define PSP_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define PSP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle
`define PSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PSP_ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define PSP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define PSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ sv/psp_pkg.sv @@
package psp_pkg;

    // Line buffer capacity; only LINE_CAPACITY-1 bytes of a line count
    localparam int LINE_CAPACITY = 64;
    localparam int LEN_W         = $clog2(LINE_CAPACITY);

    // Sentence tag
    localparam int TAG_LEN = 6;
    localparam int TAG_IDX_W = $clog2(TAG_LEN);
    localparam logic [7:0] TAG_BYTES [TAG_LEN] = '{
        8'h24, 8'h44, 8'h46, 8'h48, 8'h50, 8'h44   // $ D F H P D
    };

    // Byte codes
    localparam logic [7:0] BYTE_NUL   = 8'h00;
    localparam logic [7:0] BYTE_NL    = 8'h0A;
    localparam logic [7:0] BYTE_COMMA = 8'h2C;
    localparam logic [7:0] BYTE_DIG0  = 8'h30;
    localparam logic [7:0] BYTE_DIG1  = 8'h31;

    // One result beat
    typedef struct packed {
        logic occupied;
        logic changed;
        logic tag_matched;
    } t_result;

endpackage

@@ sv/presence_sentence_parser.sv @@
// Channel   Valid        Ready        Payload
// rx byte   i_rx_valid   o_rx_ready   i_rx_byte
// result    o_res_valid  i_res_ready  o_occupied, o_changed, o_tag_matched
//
// One byte per cycle while o_rx_ready is high; a newline's result is registered in the output buffer.
// The line state updates in a single pass from the state registers and the byte.
// Synchronous active-low reset clears line state and occupancy; the tag-match flag resets to one.
// A two-beat output buffer lets bytes keep flowing while a result waits;
// o_rx_ready drops only when both result slots are full.
module presence_sentence_parser import psp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic       o_occupied,
    output logic       o_changed,
    output logic       o_tag_matched
);

    logic    take;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign take = i_rx_valid && o_rx_ready;

    psp_line_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    psp_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_res   (res),
        .o_ready (o_rx_ready),
        .o_valid (o_res_valid),
        .o_res   (out_res),
        .i_ready (i_res_ready)
    );

    assign o_occupied    = out_res.occupied;
    assign o_changed     = out_res.changed;
    assign o_tag_matched = out_res.tag_matched;

endmodule

@@ sv/psp_line_parse.sv @@
`include "presence_sentence_parser_defines.svh"

// Per-byte line state and the end-of-line verdict
module psp_line_parse import psp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,       // byte accepted this cycle
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,  // result produced this cycle
    output t_result     o_res
);

    logic [LEN_W-1:0] r_len,       n_len;
    logic             r_tag_ok,    n_tag_ok;
    logic             r_ended,     n_ended;
    logic [1:0]       r_commas,    n_commas;
    logic             r_dig_seen,  n_dig_seen;
    logic             r_dig_val,   n_dig_val;
    logic             r_occ,       n_occ;

    logic             is_nl;
    logic             in_tag;
    logic             matched;
    logic             line_ok;

    assign is_nl   = (i_rx_byte == BYTE_NL);
    assign in_tag  = (r_len < LEN_W'(TAG_LEN));
    assign matched = r_tag_ok && (r_len >= LEN_W'(TAG_LEN));
    assign line_ok = matched && (r_commas == 2'd2) && r_dig_seen;

    // Next line state
    always_comb begin
        n_len      = r_len;
        n_tag_ok   = r_tag_ok;
        n_ended    = r_ended;
        n_commas   = r_commas;
        n_dig_seen = r_dig_seen;
        n_dig_val  = r_dig_val;
        n_occ      = r_occ;
        if (i_take) begin
            if (is_nl) begin
                if (line_ok) begin
                    n_occ = r_dig_val;
                end
                n_len      = '0;
                n_tag_ok   = 1'b1;
                n_ended    = 1'b0;
                n_commas   = 2'd0;
                n_dig_seen = 1'b0;
                n_dig_val  = 1'b0;
            end else if (r_len < LEN_W'(LINE_CAPACITY - 1)) begin
                n_len = r_len + LEN_W'(1);
                if (!r_ended) begin
                    if (i_rx_byte == BYTE_NUL) begin
                        n_ended = 1'b1;
                        if (in_tag) begin
                            n_tag_ok = 1'b0;
                        end
                    end else begin
                        if (in_tag && (i_rx_byte != TAG_BYTES[r_len[TAG_IDX_W-1:0]])) begin
                            n_tag_ok = 1'b0;
                        end
                        if (i_rx_byte == BYTE_COMMA) begin
                            if (r_commas != 2'd2) begin
                                n_commas = r_commas + 2'd1;
                            end
                        end else if ((r_commas == 2'd1) && !r_dig_seen) begin
                            if (i_rx_byte == BYTE_DIG1) begin
                                n_dig_seen = 1'b1;
                                n_dig_val  = 1'b1;
                            end else if (i_rx_byte == BYTE_DIG0) begin
                                n_dig_seen = 1'b1;
                                n_dig_val  = 1'b0;
                            end
                        end
                    end
                end
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_tag_ok   <= 1'b1;
            r_ended    <= 1'b0;
            r_commas   <= 2'd0;
            r_dig_seen <= 1'b0;
            r_dig_val  <= 1'b0;
            r_occ      <= 1'b0;
        end else begin
            r_len      <= n_len;
            r_tag_ok   <= n_tag_ok;
            r_ended    <= n_ended;
            r_commas   <= n_commas;
            r_dig_seen <= n_dig_seen;
            r_dig_val  <= n_dig_val;
            r_occ      <= n_occ;
        end
    end

    // Verdict on newline
    assign o_res_valid     = i_take && is_nl;
    assign o_res.occupied  = n_occ;
    assign o_res.changed   = line_ok && (r_dig_val != r_occ);
    assign o_res.tag_matched = matched;

    `PSP_ASSERT_ALWAYS(a_commas_sat, i_clk, i_rst_n, r_commas != 2'd3, "comma count overran")
    `PSP_ASSERT_IMPLIES(a_digit_after_comma, i_clk, i_rst_n, r_dig_seen, r_commas != 2'd0,
        "digit seen before first comma")
    `PSP_ASSERT_IMPLIES(a_fresh_line, i_clk, i_rst_n, r_len == '0,
        r_tag_ok && !r_ended && (r_commas == 2'd0) && !r_dig_seen, "stale state on empty line")

endmodule

@@ sv/psp_out_buf.sv @@
`include "presence_sentence_parser_defines.svh"

// Output register with a skid stage behind it
module psp_out_buf import psp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_res,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_ready
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    drain;

    assign drain   = r_out_valid && i_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (drain) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (i_valid) begin
                if (r_out_valid && !drain) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (drain) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (drain) begin
                r_out <= r_skid;
            end
        end else if (i_valid) begin
            if (r_out_valid && !drain) begin
                r_skid <= i_res;
            end else begin
                r_out <= i_res;
            end
        end
    end

    `PSP_ASSERT_IMPLIES(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid holds a beat with output empty")
    `PSP_ASSERT_IMPLIES(a_no_overflow, i_clk, i_rst_n, i_valid, !r_skid_valid,
        "result arrived with skid full")
    `PSP_ASSERT_NEXT(a_drain_empties, i_clk, i_rst_n, drain && !r_skid_valid && !i_valid,
        !r_out_valid, "output kept a drained beat")

endmodule

@@ bench/presence_sentence_parser_check.sv @@
`timescale 1ns / 1ps

// Watches both channels of the sentence parser, tracks the line state and the
// stored occupancy itself, and compares every result beat with the oldest
// outcome still waiting.
module presence_sentence_parser_check import psp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    input  logic       i_rx_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_res_valid,
    input  logic       i_res_ready,
    input  logic       i_occupied,
    input  logic       i_changed,
    input  logic       i_tag_matched,
    output int         o_fail_count,
    output int         o_outstanding
);

    // Own copy of the line state
    int         line_len;
    logic       tag_ok;
    logic       text_done;
    logic [1:0] comma_cnt;
    logic       digit_seen;
    logic       digit_val;
    logic       occ_now;

    // Outcomes of accepted newlines, oldest first
    t_result    line_outcomes[$];
    int         fails = 0;

    assign o_fail_count = fails;

    task automatic clear_line();
        line_len   = 0;
        tag_ok     = 1'b1;
        text_done  = 1'b0;
        comma_cnt  = 2'd0;
        digit_seen = 1'b0;
        digit_val  = 1'b0;
    endtask

    // Fold one received byte into the line; a newline closes the sentence
    task automatic parse_byte(input logic [7:0] b);
        t_result r;
        int      pos;
        if (b == BYTE_NL) begin
            r.tag_matched = tag_ok && (line_len >= TAG_LEN);
            r.changed     = 1'b0;
            if (r.tag_matched && comma_cnt == 2'd2 && digit_seen && digit_val != occ_now) begin
                occ_now   = digit_val;
                r.changed = 1'b1;
            end
            r.occupied = occ_now;
            line_outcomes.push_back(r);
            clear_line();
        end else if (line_len < LINE_CAPACITY - 1) begin
            pos      = line_len;
            line_len = line_len + 1;
            if (!text_done) begin
                if (b == BYTE_NUL) begin
                    // NUL ends the text; inside the tag it spoils the match
                    text_done = 1'b1;
                    if (pos < TAG_LEN)
                        tag_ok = 1'b0;
                end else begin
                    if (pos < TAG_LEN && b != TAG_BYTES[pos])
                        tag_ok = 1'b0;
                    if (b == BYTE_COMMA) begin
                        if (comma_cnt != 2'd2)
                            comma_cnt = comma_cnt + 2'd1;
                    end else if (comma_cnt == 2'd1 && !digit_seen) begin
                        // first 0/1 in the second field wins
                        if (b == BYTE_DIG1) begin
                            digit_seen = 1'b1;
                            digit_val  = 1'b1;
                        end else if (b == BYTE_DIG0) begin
                            digit_seen = 1'b1;
                            digit_val  = 1'b0;
                        end
                    end
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic want, input logic got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    // Result beats are compared before the byte of the same edge is folded in
    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            clear_line();
            occ_now = 1'b0;
            line_outcomes.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (line_outcomes.size() == 0) begin
                    $error("result beat with no sentence outstanding");
                    fails++;
                end else begin
                    want = line_outcomes.pop_front();
                    check_field("occupied", want.occupied, i_occupied);
                    check_field("changed", want.changed, i_changed);
                    check_field("tag_matched", want.tag_matched, i_tag_matched);
                end
            end
            if (i_rx_valid && i_rx_ready)
                parse_byte(i_rx_byte);
        end
        o_outstanding = line_outcomes.size();
    end

endmodule

@@ bench/presence_sentence_parser_test.sv @@
`timescale 1ns / 1ps

module presence_sentence_parser_test;
    import psp_pkg::*;

    localparam int BYTE_TARGET = 1350;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       rx_valid = 1'b0;
    logic [7:0] rx_byte = 8'h00;
    logic       res_ready = 1'b0;
    wire        rx_ready;
    wire        res_valid;
    wire        occupied;
    wire        changed;
    wire        tag_matched;

    int         fail_count;
    int         outstanding;
    int         bytes_sent = 0;

    // receiver pacing
    logic       hold_req = 1'b0;
    int         hold_left = 0;
    int         run_left = 0;
    logic       run_level = 1'b0;

    logic [7:0] line_q[$];

    always #10 i_clk = ~i_clk;

    presence_sentence_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (rx_valid),
        .o_rx_ready    (rx_ready),
        .i_rx_byte     (rx_byte),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_occupied    (occupied),
        .o_changed     (changed),
        .o_tag_matched (tag_matched)
    );

    presence_sentence_parser_check u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (rx_valid),
        .i_rx_ready    (rx_ready),
        .i_rx_byte     (rx_byte),
        .i_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .i_occupied    (occupied),
        .i_changed     (changed),
        .i_tag_matched (tag_matched),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] junk_char();
        return 8'($urandom_range(32, 126));
    endfunction

    // Receiver: alternating ready/stall runs, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            res_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            res_ready <= 1'b0;
        end else begin
            if (run_left == 0) begin
                run_level = !run_level;
                run_left  = run_level ? $urandom_range(1, 24) : pick_gap();
                if (run_left == 0) begin
                    run_level = 1'b1;
                    run_left  = $urandom_range(1, 24);
                end
            end
            run_left--;
            res_ready <= run_level;
        end
    end

    // One beat on the rx channel, optionally after an idle gap
    task automatic send_byte(input logic [7:0] b, input bit gappy);
        int g;
        g = gappy ? pick_gap() : 0;
        if (g != 0) begin
            @(negedge i_clk);
            rx_valid <= 1'b0;
            rx_byte  <= 8'($urandom_range(0, 255));
            repeat (g - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge i_clk); while (!rx_ready);
        bytes_sent++;
    endtask

    task automatic send_line(input bit gappy);
        foreach (line_q[i])
            send_byte(line_q[i], gappy);
        line_q.delete();
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_q.push_back(s[i]);
    endtask

    task automatic push_junk(input int n);
        repeat (n) line_q.push_back(junk_char());
    endtask

    // Stop offering and wait for every outstanding result beat
    task automatic drain_results();
        @(negedge i_clk);
        rx_valid <= 1'b0;
        wait (outstanding == 0);
    endtask

    // Build one line: mostly tagged sentences with random content, some mangled, some noise
    task automatic make_sentence();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            n = $urandom_range(0, 24);
            repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            push_text("$DFHPD");
            if ($urandom_range(0, 9) == 0)
                line_q[$urandom_range(0, TAG_LEN - 1)] = 8'($urandom_range(0, 255));
            push_junk($urandom_range(0, 3));
            // long line: may push the fields past the capacity
            if ($urandom_range(0, 19) == 0)
                push_junk($urandom_range(40, 70));
            line_q.push_back(BYTE_COMMA);
            push_junk($urandom_range(0, 2));
            n = $urandom_range(0, 3);
            repeat (n) begin
                if ($urandom_range(0, 3) == 0)
                    line_q.push_back(junk_char());
                else
                    line_q.push_back($urandom_range(0, 1) ? BYTE_DIG1 : BYTE_DIG0);
            end
            push_junk($urandom_range(0, 2));
            if ($urandom_range(0, 7) != 0)
                line_q.push_back(BYTE_COMMA);
            push_junk($urandom_range(0, 8));
            if ($urandom_range(0, 3) == 0)
                line_q.push_back(8'h0D);
            if ($urandom_range(0, 11) == 0)
                line_q[$urandom_range(0, line_q.size() - 1)] = BYTE_NUL;
            // short line
            if ($urandom_range(0, 11) == 0) begin
                n = $urandom_range(0, TAG_LEN - 1);
                while (line_q.size() > n)
                    void'(line_q.pop_back());
            end
        end
        line_q.push_back(BYTE_NL);
    endtask

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("TEST FAILED");
        $finish;
    end

    // Stimulus and verdict
    initial begin
        bit held;
        bit paused;
        held   = 1'b0;
        paused = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty line, accepted sentence, digit without a closing comma, NUL and 0xFF
        push_text("\n$DFHPD,1,\n$DFHPD,0\n");
        send_line(1'b1);
        send_byte(BYTE_NUL, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(BYTE_NL, 1'b1);
        drain_results();

        while (bytes_sent < BYTE_TARGET) begin
            if (!held && bytes_sent >= 500) begin
                // receiver stalls while a burst of empty lines backs up the block
                held     = 1'b1;
                hold_req = 1'b1;
                repeat (40) line_q.push_back(BYTE_NL);
                send_line(1'b0);
            end else if (!paused && bytes_sent >= 900) begin
                paused = 1'b1;
                drain_results();
            end else begin
                make_sentence();
                send_line($urandom_range(0, 3) != 0);
            end
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/psp_pkg.sv
sv/psp_line_parse.sv
sv/psp_out_buf.sv
sv/presence_sentence_parser.sv
bench/presence_sentence_parser_check.sv
bench/presence_sentence_parser_test.sv
